// ===== rtl/lcbas_pkg.sv =====
// shared types and constants of the led cube bit angle scan
package lcbas_pkg;

  localparam int COORD_W = 3;
  localparam int DIM     = 8;
  localparam int LEVEL_W = 8;
  localparam int ROW_AW  = 2 * COORD_W;
  localparam int ROW_W   = DIM * LEVEL_W;
  localparam int ROWS    = DIM * DIM;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] voxel_x;
    logic [COORD_W-1:0] voxel_y;
    logic [COORD_W-1:0] voxel_z;
    logic [LEVEL_W-1:0] brightness;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] layer_index;
    logic [DIM-1:0]     layer_select;
    logic [ROW_W-1:0]   column_bits;
  } result_t;

  // one write beat into the voxel store
  typedef struct packed {
    logic               en;
    logic               fill;
    logic [ROW_AW-1:0]  addr;
    logic [COORD_W-1:0] lane;
    logic [LEVEL_W-1:0] value;
  } store_wr_t;

endpackage

// ===== rtl/lcbas_store.sv =====
// voxel store: 64 rows of eight brightness bytes, fill value and row valid bits
module lcbas_store
  import lcbas_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         wr,
  input  logic              rd_en,
  input  logic [ROW_AW-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data
);

  logic [ROW_W-1:0]   mem [ROWS];
  logic [ROWS-1:0]    row_valid;
  logic [LEVEL_W-1:0] fill_value;
  logic [ROW_W-1:0]   rd_raw;
  logic               rd_row_valid;

  // a row not yet written since the last fill reads as the fill value
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      fill_value <= '0;
    end else if (wr.en) begin
      if (wr.fill) begin
        row_valid  <= '0;
        fill_value <= wr.value;
      end else begin
        row_valid[wr.addr] <= 1'b1;
      end
    end
  end

  // byte-lane write; a row that is not valid gets the fill value in its other lanes
  always_ff @(posedge clk) begin
    if (wr.en && !wr.fill) begin
      for (int b = 0; b < DIM; b++) begin
        if (b == int'(wr.lane)) begin
          mem[wr.addr][b*LEVEL_W +: LEVEL_W] <= wr.value;
        end else if (!row_valid[wr.addr]) begin
          mem[wr.addr][b*LEVEL_W +: LEVEL_W] <= fill_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw       <= mem[rd_addr];
      rd_row_valid <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_row_valid ? rd_raw : {DIM{fill_value}};

endmodule

// ===== rtl/led_cube_bit_angle_scan.sv =====
// top level of the led cube bit angle scan
//
// A beat is taken when start is high and busy is low. A tick (operation 0)
// advances the driven layer and gives one result beat on result, marked by
// done for one cycle, in the cycle after the tick was taken; busy stays low,
// so ticks may follow back to back. When a tick ends the hold time of the
// current bit plane, the next plane is sliced out of the voxel store into
// the per-layer column buffer: the store is read one row of eight voxels a
// cycle through its single read port, 64 rows; busy stays high through the
// slice, drain and emit states, and the result beat follows in the cycle
// after emit. A voxel write (operation 1) or a fill (operation 2) gives no
// result; operation 3 does nothing. The store comes out of reset as all
// zero at once (row valid bits), with no clearing pass. The receiver
// cannot hold off a result: done marks each beat for exactly one cycle.
module led_cube_bit_angle_scan
  import lcbas_pkg::*;
#(
  parameter int CUBE_SIZE       = 8,
  parameter int BRIGHTNESS_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SLICE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t             state;
  logic [COORD_W-1:0] active_layer;
  logic [LEVEL_W-1:0] sweep_count;
  logic [COORD_W-1:0] bit_plane;
  logic [ROW_AW-1:0]  slice_cnt;
  logic               rd_pend;
  logic [ROW_AW-1:0]  rd_row;
  logic [ROW_W-1:0]   plane_buffer [DIM];

  logic               accept;
  store_wr_t          wr;
  logic [ROW_W-1:0]   rd_data;
  logic               rd_en;

  // advance of layer, sweep and plane for a tick
  logic [COORD_W:0]   layer_inc;
  logic               layer_wrap;
  logic [LEVEL_W-1:0] count_inc;
  logic               plane_done;
  logic [COORD_W:0]   plane_inc;
  logic [COORD_W-1:0] plane_next;
  logic [COORD_W-1:0] layer_next;
  logic               coords_ok;
  logic [DIM-1:0]     slice_bits;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign layer_inc  = {1'b0, active_layer} + 1'b1;
  assign layer_wrap = (layer_inc >= (COORD_W+1)'(CUBE_SIZE));
  assign layer_next = layer_wrap ? '0 : layer_inc[COORD_W-1:0];
  assign count_inc  = sweep_count + 1'b1;
  assign plane_done = layer_wrap && (count_inc == (LEVEL_W'(1) << bit_plane));
  assign plane_inc  = {1'b0, bit_plane} + 1'b1;
  assign plane_next = (plane_inc >= (COORD_W+1)'(BRIGHTNESS_BITS)) ? '0
                                                                    : plane_inc[COORD_W-1:0];

  // writes outside the cube are dropped
  assign coords_ok = (int'(cmd.voxel_x) < CUBE_SIZE) && (int'(cmd.voxel_y) < CUBE_SIZE) &&
                     (int'(cmd.voxel_z) < CUBE_SIZE);

  // store row address is {x, z}; byte lane y within the row
  always_comb begin
    wr       = '0;
    wr.addr  = {cmd.voxel_x, cmd.voxel_z};
    wr.lane  = cmd.voxel_y;
    wr.value = cmd.brightness;
    if (accept && cmd.operation == OP_WRITE && coords_ok) begin
      wr.en = 1'b1;
    end else if (accept && cmd.operation == OP_FILL) begin
      wr.en   = 1'b1;
      wr.fill = 1'b1;
    end
  end

  assign rd_en = (state == ST_SLICE);

  // the store is never read and written in the same cycle: writes are only
  // taken while idle and reads only happen during the slicing sweep
  lcbas_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (slice_cnt),
    .rd_data (rd_data)
  );

  // pick the plane bit out of each of the row's eight voxels, cells outside the cube stay zero
  always_comb begin
    for (int y = 0; y < DIM; y++) begin
      slice_bits[y] = rd_data[{COORD_W'(y), bit_plane}] && (y < CUBE_SIZE) &&
                      (int'(rd_row[ROW_AW-1:COORD_W]) < CUBE_SIZE) &&
                      (int'(rd_row[COORD_W-1:0]) < CUBE_SIZE);
    end
  end

  // sequencer and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_layer <= '0;
      sweep_count  <= '0;
      bit_plane    <= '0;
      slice_cnt    <= '0;
      rd_pend      <= 1'b0;
      done         <= 1'b0;
      for (int z = 0; z < DIM; z++) begin
        plane_buffer[z] <= '0;
      end
    end else begin
      done    <= 1'b0;
      rd_pend <= (state == ST_SLICE);
      case (state)
        ST_IDLE: begin
          if (accept && cmd.operation == OP_TICK) begin
            active_layer <= layer_next;
            if (plane_done) begin
              // new plane: refill the column buffer before the result goes out
              sweep_count <= '0;
              bit_plane   <= plane_next;
              slice_cnt   <= '0;
              state       <= ST_SLICE;
            end else begin
              if (layer_wrap) begin
                sweep_count <= count_inc;
              end
              done <= 1'b1;
            end
          end
        end
        ST_SLICE: begin
          slice_cnt <= slice_cnt + 1'b1;
          if (slice_cnt == ROW_AW'(ROWS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // read data lands in the cycle after the address: byte x of layer z's columns
      if (rd_pend) begin
        plane_buffer[rd_row[COORD_W-1:0]][{rd_row[ROW_AW-1:COORD_W], 3'b000} +: DIM] <=
          slice_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SLICE) begin
      rd_row <= slice_cnt;
    end
  end

  // result register, loaded for a plain tick or at the end of a refill
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && cmd.operation == OP_TICK && !plane_done) begin
      result.layer_index  <= layer_next;
      result.layer_select <= DIM'(1) << layer_next;
      result.column_bits  <= plane_buffer[layer_next];
    end else if (state == ST_EMIT) begin
      result.layer_index  <= active_layer;
      result.layer_select <= DIM'(1) << active_layer;
      result.column_bits  <= plane_buffer[active_layer];
    end
  end

endmodule
